// ----- hw/rtl/r4map_pkg.sv -----
// package for the raid-4 map and parity unit
// shared constants, action codes, config and divider status types
// no dependencies
`timescale 1ns / 1ps

package r4map_pkg;

    localparam int MAX_MEMBERS  = 16;
    localparam int WORD_BITS    = 64;
    localparam int ADDR_BITS    = 48;
    localparam int MEMBER_BITS  = $clog2(MAX_MEMBERS);
    localparam int SHIFT_BITS   = 5;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;
    localparam int DIV_CNT_W    = $clog2(ADDR_BITS);

    localparam logic [SHIFT_BITS-1:0] BLK_LOG2_MIN   = 5'd9;
    localparam logic [SHIFT_BITS-1:0] BLK_LOG2_MAX   = 5'd20;
    localparam logic [SHIFT_BITS-1:0] BLK_LOG2_RESET = 5'd12;
    localparam logic [MEMBER_BITS-1:0] DISKS_RESET   = 4'd3;
    localparam logic [MEMBER_BITS-1:0] DISKS_MAX     = MEMBER_BITS'(MAX_MEMBERS - 1);
    localparam logic [MEMBER_BITS:0]  MISSING_RESET  = (MEMBER_BITS+1)'(MAX_MEMBERS);

    typedef enum logic [1:0] {
        ACT_MAP_READ  = 2'd0,
        ACT_MAP_WRITE = 2'd1,
        ACT_FOLD      = 2'd2,
        ACT_UNUSED    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_BLK_LOG2   = 2'd0,
        REG_DATA_DISKS = 2'd1,
        REG_MISSING    = 2'd2,
        REG_NONE       = 2'd3
    } reg_index_t;

    // effective (saturated) configuration
    typedef struct packed {
        logic [SHIFT_BITS-1:0]  blk_log2;
        logic [MEMBER_BITS-1:0] data_disks;
        logic [MEMBER_BITS:0]   missing;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- hw/rtl/r4map_apb_regs.sv -----
// apb configuration registers of the raid-4 map and parity unit
// holds block size, data disk count and missing member; depends on r4map_pkg
`timescale 1ns / 1ps

module r4map_apb_regs
    import r4map_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [SHIFT_BITS-1:0]  blk_log2_reg;
    logic [MEMBER_BITS-1:0] disks_reg;
    logic [MEMBER_BITS:0]   missing_reg;
    reg_index_t             idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_log2_reg <= BLK_LOG2_RESET;
            disks_reg    <= DISKS_RESET;
            missing_reg  <= MISSING_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_BLK_LOG2:   blk_log2_reg <= pwdata[SHIFT_BITS-1:0];
                REG_DATA_DISKS: disks_reg    <= pwdata[MEMBER_BITS-1:0];
                REG_MISSING:    missing_reg  <= pwdata[MEMBER_BITS:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_BLK_LOG2:   prdata = APB_DATA_W'(blk_log2_reg);
            REG_DATA_DISKS: prdata = APB_DATA_W'(disks_reg);
            REG_MISSING:    prdata = APB_DATA_W'(missing_reg);
            default:        prdata = '0;
        endcase
    end

    // saturate block size and data disk count into the legal ranges; missing passes through
    always_comb begin
        if (blk_log2_reg < BLK_LOG2_MIN) begin
            cfg.blk_log2 = BLK_LOG2_MIN;
        end else if (blk_log2_reg > BLK_LOG2_MAX) begin
            cfg.blk_log2 = BLK_LOG2_MAX;
        end else begin
            cfg.blk_log2 = blk_log2_reg;
        end
        if (disks_reg == '0) begin
            cfg.data_disks = MEMBER_BITS'(1);
        end else if (disks_reg > DISKS_MAX) begin
            cfg.data_disks = DISKS_MAX;
        end else begin
            cfg.data_disks = disks_reg;
        end
        cfg.missing = missing_reg;
    end

endmodule

// ----- hw/rtl/r4map_divider.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// divides the block number by the data disk count; depends on r4map_pkg
`timescale 1ns / 1ps

module r4map_divider
    import r4map_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [ADDR_BITS-1:0]   dividend,
    input  logic [MEMBER_BITS-1:0] divisor,
    output logic [ADDR_BITS-1:0]   quotient,
    output logic [MEMBER_BITS-1:0] remainder,
    output div_stat_t              stat
);

    logic [ADDR_BITS-1:0]   quo_reg,  quo_next;
    logic [MEMBER_BITS-1:0] rem_reg,  rem_next;
    logic [MEMBER_BITS-1:0] dsr_reg,  dsr_next;
    logic [DIV_CNT_W-1:0]   cnt_reg,  cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [MEMBER_BITS:0]   trial;
    logic [MEMBER_BITS:0]   diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[ADDR_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[ADDR_BITS-2:0], fits};
            rem_next = fits ? diff[MEMBER_BITS-1:0] : trial[MEMBER_BITS-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(ADDR_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- hw/rtl/raid4_map_and_parity_unit.sv -----
// top level of the raid-4 map and parity unit
// sequencer, fold accumulator and output register; uses r4map_pkg,
// r4map_apb_regs and r4map_divider
`timescale 1ns / 1ps

// Usage
// Input words arrive on the s_ channel (valid/ready) and results leave on
// the m_ channel (valid/ready). Configuration goes through the apb port at
// byte addresses 0 (block size log2), 4 (data disks), 8 (missing member).
// A map read or map write splits the block number through a shared
// one-bit-per-cycle divider over all 48 address bits: the result is
// registered from the divider into the pending registers and s_ready
// stays low until it is moved into the output register. A fold word is
// folded into the accumulator as it is accepted; the last word of a set
// gives its rebuilt word via the pending registers. The unused action
// code is dropped with no result.
// A finished result waits in the output register while the next word is
// accepted and processed; if the receiver still stalls when the next
// result is ready, the block holds it and keeps s_ready low.
// Reset (aresetn, synchronous, active low) restores the configuration
// defaults, clears the fold accumulator and empties the output register.

module raid4_map_and_parity_unit
    import r4map_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic [ADDR_BITS-1:0]   s_logical_offset,
    input  logic [WORD_BITS-1:0]   s_new_word,
    input  logic [WORD_BITS-1:0]   s_old_word,
    input  logic [WORD_BITS-1:0]   s_old_parity,
    input  logic                   s_last_of_set,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [MEMBER_BITS-1:0] m_member_index,
    output logic [ADDR_BITS-1:0]   m_member_offset,
    output logic                   m_member_missing,
    output logic [WORD_BITS-1:0]   m_data_out,
    output logic                   m_data_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    cfg_t                   cfg;
    div_stat_t              div_stat;
    logic [ADDR_BITS-1:0]   quotient;
    logic [MEMBER_BITS-1:0] remainder;
    logic                   div_start;
    logic [ADDR_BITS-1:0]   blk;
    logic [ADDR_BITS-1:0]   inblk_mask;
    logic [MEMBER_BITS-1:0] member;
    logic                   accept;
    action_t                act;

    state_t                 state_reg,   state_next;
    logic [WORD_BITS-1:0]   acc_reg,     acc_next;
    logic [SHIFT_BITS-1:0]  sh_reg,      sh_next;
    logic [ADDR_BITS-1:0]   inblk_reg,   inblk_next;
    logic [MEMBER_BITS-1:0] p_index_reg, p_index_next;
    logic [ADDR_BITS-1:0]   p_off_reg,   p_off_next;
    logic                   p_miss_reg,  p_miss_next;
    logic [WORD_BITS-1:0]   p_data_reg,  p_data_next;
    logic                   p_dval_reg,  p_dval_next;
    logic                   m_valid_reg, m_valid_next;
    logic [MEMBER_BITS-1:0] m_index_reg, m_index_next;
    logic [ADDR_BITS-1:0]   m_off_reg,   m_off_next;
    logic                   m_miss_reg,  m_miss_next;
    logic [WORD_BITS-1:0]   m_data_reg,  m_data_next;
    logic                   m_dval_reg,  m_dval_next;

    r4map_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    r4map_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (blk),
        .divisor   (cfg.data_disks),
        .quotient  (quotient),
        .remainder (remainder),
        .stat      (div_stat)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid & s_ready;
    assign act        = action_t'(s_action);
    assign blk        = s_logical_offset >> cfg.blk_log2;
    assign inblk_mask = (ADDR_BITS'(1) << cfg.blk_log2) - ADDR_BITS'(1);
    assign div_start  = accept & ((act == ACT_MAP_READ) | (act == ACT_MAP_WRITE));
    assign member     = remainder + MEMBER_BITS'(1);

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        sh_next      = sh_reg;
        inblk_next   = inblk_reg;
        p_index_next = p_index_reg;
        p_off_next   = p_off_reg;
        p_miss_next  = p_miss_reg;
        p_data_next  = p_data_reg;
        p_dval_next  = p_dval_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        m_index_next = m_index_reg;
        m_off_next   = m_off_reg;
        m_miss_next  = m_miss_reg;
        m_data_next  = m_data_reg;
        m_dval_next  = m_dval_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (act)
                        ACT_MAP_READ: begin
                            sh_next     = cfg.blk_log2;
                            inblk_next  = s_logical_offset & inblk_mask;
                            p_data_next = '0;
                            p_dval_next = 1'b0;
                            state_next  = ST_DIV;
                        end
                        ACT_MAP_WRITE: begin
                            sh_next     = cfg.blk_log2;
                            inblk_next  = s_logical_offset & inblk_mask;
                            p_data_next = s_old_parity ^ s_old_word ^ s_new_word;
                            p_dval_next = 1'b1;
                            state_next  = ST_DIV;
                        end
                        ACT_FOLD: begin
                            if (s_last_of_set) begin
                                acc_next     = '0;
                                p_index_next = '0;
                                p_off_next   = '0;
                                p_miss_next  = 1'b0;
                                p_data_next  = acc_reg ^ s_new_word;
                                p_dval_next  = 1'b1;
                                state_next   = ST_FINISH;
                            end else begin
                                acc_next = acc_reg ^ s_new_word;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    p_index_next = member;
                    p_off_next   = (quotient << sh_reg) | inblk_reg;
                    p_miss_next  = ~cfg.missing[MEMBER_BITS]
                                 & (cfg.missing[MEMBER_BITS-1:0] == member);
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_index_next = p_index_reg;
                    m_off_next   = p_off_reg;
                    m_miss_next  = p_miss_reg;
                    m_data_next  = p_data_reg;
                    m_dval_next  = p_dval_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
        sh_reg      <= sh_next;
        inblk_reg   <= inblk_next;
        p_index_reg <= p_index_next;
        p_off_reg   <= p_off_next;
        p_miss_reg  <= p_miss_next;
        p_data_reg  <= p_data_next;
        p_dval_reg  <= p_dval_next;
        m_index_reg <= m_index_next;
        m_off_reg   <= m_off_next;
        m_miss_reg  <= m_miss_next;
        m_data_reg  <= m_data_next;
        m_dval_reg  <= m_dval_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_member_index   = m_index_reg;
    assign m_member_offset  = m_off_reg;
    assign m_member_missing = m_miss_reg;
    assign m_data_out       = m_data_reg;
    assign m_data_valid     = m_dval_reg;

endmodule

// ----- bench/tb_raid4_map_and_parity_unit.sv -----
// testbench for raid4_map_and_parity_unit: directed and random map, write and fold words,
// checked word by word against an in-bench stripe model; uses r4map_pkg and the rtl top
`timescale 1ns / 1ps

module tb_raid4_map_and_parity_unit;
    import r4map_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int PRINT_LIMIT   = 50;

    typedef struct packed {
        logic [MEMBER_BITS-1:0] member_index;
        logic [ADDR_BITS-1:0]   member_offset;
        logic                   member_missing;
        logic [WORD_BITS-1:0]   data_out;
        logic                   data_valid;
    } stripe_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_action = '0;
    logic [ADDR_BITS-1:0]   s_logical_offset = '0;
    logic [WORD_BITS-1:0]   s_new_word = '0;
    logic [WORD_BITS-1:0]   s_old_word = '0;
    logic [WORD_BITS-1:0]   s_old_parity = '0;
    logic                   s_last_of_set = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [MEMBER_BITS-1:0] m_member_index;
    logic [ADDR_BITS-1:0]   m_member_offset;
    logic                   m_member_missing;
    logic [WORD_BITS-1:0]   m_data_out;
    logic                   m_data_valid;

    // stripe model state
    logic [SHIFT_BITS-1:0]  blk_log2_reg = BLK_LOG2_RESET;
    logic [MEMBER_BITS-1:0] disks_reg = DISKS_RESET;
    logic [MEMBER_BITS:0]   missing_reg = MISSING_RESET;
    logic [WORD_BITS-1:0]   fold_acc = '0;
    stripe_result_t         stripe_q[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    int n_configs = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_folds = 0;
    int n_rebuilt = 0;

    raid4_map_and_parity_unit dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d words outstanding", stripe_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("mismatch on %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand_offset();
        case ($urandom_range(2))
            0: return ADDR_BITS'($urandom_range(0, 1 << 23));
            1: return {ADDR_BITS{1'b1}} - ADDR_BITS'($urandom_range(0, 65535));
            default: return ADDR_BITS'(rand_word());
        endcase
    endfunction

    // block mapping, parity update and fold accumulation
    function automatic void raid_map_fold(input action_t act, input logic [ADDR_BITS-1:0] offs,
                                          input logic [WORD_BITS-1:0] nw, ow, op,
                                          input logic last);
        logic [SHIFT_BITS-1:0]  sh;
        logic [MEMBER_BITS-1:0] d;
        logic [ADDR_BITS-1:0]   blk;
        logic [ADDR_BITS-1:0]   quo;
        logic [MEMBER_BITS-1:0] rem;
        stripe_result_t         r;
        r = '0;
        case (act)
            ACT_UNUSED: return;
            ACT_FOLD: begin
                fold_acc = fold_acc ^ nw;
                if (!last)
                    return;
                r.data_out = fold_acc;
                r.data_valid = 1'b1;
                fold_acc = '0;
                n_rebuilt++;
            end
            default: begin
                sh = (blk_log2_reg < BLK_LOG2_MIN) ? BLK_LOG2_MIN :
                     (blk_log2_reg > BLK_LOG2_MAX) ? BLK_LOG2_MAX : blk_log2_reg;
                d = (disks_reg == '0) ? MEMBER_BITS'(1) : disks_reg;
                blk = offs >> sh;
                quo = blk / d;
                rem = MEMBER_BITS'(blk % d);
                r.member_index = rem + 1'b1;
                r.member_offset = (quo << sh) | (offs & ((48'd1 << sh) - 48'd1));
                r.member_missing = (missing_reg < MAX_MEMBERS) &&
                                   (missing_reg == {1'b0, r.member_index});
                if (act == ACT_MAP_WRITE) begin
                    r.data_out = op ^ ow ^ nw;
                    r.data_valid = 1'b1;
                end
            end
        endcase
        stripe_q.push_back(r);
    endfunction

    task automatic send_word(input action_t act, input logic [ADDR_BITS-1:0] offs,
                             input logic [WORD_BITS-1:0] nw, ow, op, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_logical_offset <= offs;
        s_new_word <= nw;
        s_old_word <= ow;
        s_old_parity <= op;
        s_last_of_set <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        raid_map_fold(act, offs, nw, ow, op, last);
        case (act)
            ACT_MAP_READ: n_reads++;
            ACT_MAP_WRITE: n_writes++;
            ACT_FOLD: n_folds++;
            default: ;
        endcase
    endtask

    // wait for every pending result, then let a dropped word finish
    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (stripe_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (stripe_q.size() != 0) begin
            report_mismatch("results never delivered", stripe_q.size(), 0);
            stripe_q.delete();
        end
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_BLK_LOG2: blk_log2_reg = val[SHIFT_BITS-1:0];
            REG_DATA_DISKS: disks_reg = val[MEMBER_BITS-1:0];
            REG_MISSING: missing_reg = val[MEMBER_BITS:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] blk, dsk, miss);
        drain_results();
        write_reg(REG_BLK_LOG2, blk);
        write_reg(REG_DATA_DISKS, dsk);
        write_reg(REG_MISSING, miss);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_configs++;
    endtask

    // result side: random stall and in-order compare
    always @(posedge aclk) begin : result_check
        stripe_result_t got;
        stripe_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_member_index, m_member_offset, m_member_missing, m_data_out, m_data_valid};
            if (stripe_q.size() == 0) begin
                report_mismatch("word with nothing pending", got.data_out, 0);
            end else begin
                want = stripe_q.pop_front();
                if (got.member_index !== want.member_index)
                    report_mismatch("member_index", got.member_index, want.member_index);
                if (got.member_offset !== want.member_offset)
                    report_mismatch("member_offset", got.member_offset, want.member_offset);
                if (got.member_missing !== want.member_missing)
                    report_mismatch("member_missing", got.member_missing, want.member_missing);
                if (got.data_out !== want.data_out)
                    report_mismatch("data_out", got.data_out, want.data_out);
                if (got.data_valid !== want.data_valid)
                    report_mismatch("data_valid", got.data_valid, want.data_valid);
            end
        end
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic test_map_defaults();
        send_word(ACT_MAP_READ, '0, '0, '0, '0, 1'b0);
        send_word(ACT_MAP_READ, '1, '1, '1, '1, 1'b1);
        send_word(ACT_MAP_READ, 48'hFFF, rand_word(), rand_word(), rand_word(), 1'b0);
        send_word(ACT_MAP_READ, 48'h1000, rand_word(), rand_word(), rand_word(), 1'b1);
        send_word(ACT_MAP_WRITE, '0, '1, '0, '0, 1'b0);
        send_word(ACT_MAP_WRITE, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                  64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
        send_word(ACT_MAP_WRITE, 48'h2ABC, rand_word(), rand_word(), rand_word(), 1'b0);
    endtask

    task automatic test_fold_sets();
        send_word(ACT_FOLD, rand_offset(), rand_word(), rand_word(), rand_word(), 1'b0);
        send_word(ACT_FOLD, rand_offset(), rand_word(), rand_word(), rand_word(), 1'b0);
        send_word(ACT_FOLD, rand_offset(), rand_word(), rand_word(), rand_word(), 1'b1);
        send_word(ACT_FOLD, '1, '1, '1, '1, 1'b1);
        // unused code must leave the accumulator alone
        send_word(ACT_UNUSED, '1, '1, '1, '1, 1'b1);
        send_word(ACT_FOLD, '0, '0, '0, '0, 1'b1);
    endtask

    task automatic test_missing_member();
        set_config(9, 1, 1);
        send_word(ACT_MAP_WRITE, 48'h3039, rand_word(), rand_word(), rand_word(), 1'b0);
        send_word(ACT_MAP_READ, '1, '0, '0, '0, 1'b0);
        set_config(20, 15, 15);
        send_word(ACT_MAP_READ, (48'd14 << 20) | 48'd5, '0, '0, '0, 1'b0);
        send_word(ACT_MAP_WRITE, '1, rand_word(), rand_word(), rand_word(), 1'b1);
    endtask

    task automatic test_config_saturation();
        set_config(0, 0, 0);
        send_word(ACT_MAP_READ, rand_offset(), '0, '0, '0, 1'b0);
        send_word(ACT_MAP_WRITE, rand_offset(), rand_word(), rand_word(), rand_word(), 1'b0);
        set_config(32'hFFFF_FF1F, 32'hFFFF_FFF7, 32'hFFFF_FFFF);
        send_word(ACT_MAP_READ, '1, '0, '0, '0, 1'b1);
        send_word(ACT_MAP_WRITE, rand_offset(), rand_word(), rand_word(), rand_word(), 1'b0);
        set_config(21, 4, 16);
        send_word(ACT_MAP_READ, rand_offset(), '0, '0, '0, 1'b0);
        set_config(8, 2, 17);
        send_word(ACT_MAP_READ, rand_offset(), '0, '0, '0, 1'b0);
    endtask

    task automatic test_random_traffic(input int total);
        int per;
        int count;
        int len;
        int dd;
        logic [31:0] blk;
        logic [31:0] dsk;
        logic [31:0] miss;
        per = total / 12;
        for (int p = 0; p < 12; p++) begin
            if (p < 4) begin
                src_idle_pct = 14;
                snk_idle_pct = 80;
            end else if (p < 8) begin
                src_idle_pct = 80;
                snk_idle_pct = 14;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            blk = ($urandom_range(5) == 0) ? $urandom_range(31) : $urandom_range(9, 20);
            dsk = $urandom_range(15);
            dd = (dsk == 0) ? 1 : dsk;
            miss = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, dd);
            set_config(blk, dsk, miss);
            count = 0;
            while (count < per) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        send_word($urandom_range(1) ? ACT_MAP_WRITE : ACT_MAP_READ,
                                  rand_offset(), rand_word(), rand_word(), rand_word(),
                                  1'($urandom_range(1)));
                        count++;
                    end
                    4, 5, 6, 7, 8: begin
                        // surviving members of one stripe, last word flagged
                        len = ($urandom_range(3) == 0) ? $urandom_range(1, 15) : dd;
                        for (int k = 0; k < len; k++) begin
                            if ($urandom_range(19) == 0)
                                send_word(ACT_UNUSED, rand_offset(), rand_word(), rand_word(),
                                          rand_word(), 1'($urandom_range(1)));
                            send_word(ACT_FOLD, rand_offset(), rand_word(), rand_word(),
                                      rand_word(), k == len - 1);
                            count++;
                        end
                    end
                    default: begin
                        if ($urandom_range(1)) begin
                            send_word(ACT_UNUSED, rand_offset(), rand_word(), rand_word(),
                                      rand_word(), 1'($urandom_range(1)));
                        end else begin
                            send_word(ACT_FOLD, rand_offset(), rand_word(), rand_word(),
                                      rand_word(), 1'($urandom_range(1)));
                            count++;
                        end
                    end
                endcase
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 14;
        snk_idle_pct = 80;
        test_map_defaults();
        test_fold_sets();
        test_missing_member();
        test_config_saturation();
        test_random_traffic(650);
        drain_results();
        $display("sent %0d map reads, %0d map writes, %0d fold words (%0d rebuilt)",
                 n_reads, n_writes, n_folds, n_rebuilt);
        $display("over %0d register settings and three idle patterns, %0d mismatches",
                 n_configs, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
